@@ rtl/csme_pkg.sv @@
// Shared constants, types and decode function of the stack machine command unit.
package csme_pkg;

   localparam int STACK_DEPTH = 256;
   localparam int VALUE_BITS  = 64;
   localparam int ADDR_BITS   = $clog2(STACK_DEPTH);
   localparam int CNT_BITS    = $clog2(STACK_DEPTH + 1);

   localparam logic [VALUE_BITS-1:0] DIVZ_VALUE = VALUE_BITS'(64'd99999999);
   localparam logic [VALUE_BITS-1:0] BYTE_MASK  = VALUE_BITS'(64'hff);

   localparam logic [4:0] OP_NONE = 5'd0;
   localparam logic [4:0] OP_PUSH = 5'd1;
   localparam logic [4:0] OP_POP  = 5'd2;
   localparam logic [4:0] OP_ADD  = 5'd3;
   localparam logic [4:0] OP_SUB  = 5'd4;
   localparam logic [4:0] OP_MUL  = 5'd5;
   localparam logic [4:0] OP_DIV  = 5'd6;
   localparam logic [4:0] OP_MOD  = 5'd7;
   localparam logic [4:0] OP_NOT  = 5'd8;
   localparam logic [4:0] OP_GT   = 5'd9;
   localparam logic [4:0] OP_PTR  = 5'd10;
   localparam logic [4:0] OP_SW   = 5'd11;
   localparam logic [4:0] OP_DUP  = 5'd12;
   localparam logic [4:0] OP_ROLL = 5'd13;
   localparam logic [4:0] OP_INN  = 5'd14;
   localparam logic [4:0] OP_INC  = 5'd15;
   localparam logic [4:0] OP_OUTN = 5'd16;
   localparam logic [4:0] OP_OUTC = 5'd17;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_UNDER   = 3'd1;
   localparam logic [2:0] ST_DIVZ    = 3'd2;
   localparam logic [2:0] ST_NEGROLL = 3'd3;
   localparam logic [2:0] ST_OVER    = 3'd4;
   localparam logic [2:0] ST_NOIN    = 3'd5;

   typedef struct packed {
      logic [4:0]            op;
      logic [VALUE_BITS-1:0] value;
      logic                  present;
   } cmd_type;

   typedef struct packed {
      logic                  start;
      logic [VALUE_BITS-1:0] dividend;
      logic [VALUE_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [VALUE_BITS-1:0] quot;
      logic [VALUE_BITS-1:0] rem;
   } div_rsp_type;

   typedef struct packed {
      logic                  out_valid;
      logic [VALUE_BITS-1:0] out_value;
      logic                  out_is_char;
      logic [1:0]            direction;
      logic                  chooser;
      logic [CNT_BITS-1:0]   depth_now;
      logic [2:0]            status;
   } rsp_type;

   function automatic logic [4:0] decode_op(input logic [2:0] fhue, input logic [1:0] flit,
                                            input logic [2:0] thue, input logic [1:0] tlit);
      logic [2:0] fh;
      logic [2:0] th;
      logic [1:0] fl;
      logic [1:0] tl;
      logic [2:0] hc;
      logic [1:0] lc;
      fh = (fhue >= 3'd6) ? fhue - 3'd6 : fhue;
      th = (thue >= 3'd6) ? thue - 3'd6 : thue;
      fl = (flit == 2'd3) ? 2'd0 : flit;
      tl = (tlit == 2'd3) ? 2'd0 : tlit;
      hc = (th >= fh) ? th - fh : th + 3'd6 - fh;
      lc = (tl >= fl) ? tl - fl : tl + 2'd3 - fl;
      return ({2'b00, hc} * 5'd3) + {3'b000, lc};
   endfunction

endpackage

@@ rtl/csme_if.sv @@
// Valid/ready channel interfaces for command items and result items.
interface csme_req_if
   import csme_pkg::*;
   ();
   logic        valid;
   logic        ready;
   logic [2:0]  from_hue;
   logic [1:0]  from_light;
   logic [2:0]  to_hue;
   logic [1:0]  to_light;
   logic [23:0] block_size;
   logic signed [31:0] in_value;
   logic        in_present;

   modport source(output valid, from_hue, from_light, to_hue, to_light, block_size,
                  in_value, in_present, input ready);
   modport sink(input valid, from_hue, from_light, to_hue, to_light, block_size,
                in_value, in_present, output ready);
endinterface

interface csme_rsp_if
   import csme_pkg::*;
   ();
   logic                         valid;
   logic                         ready;
   logic                         out_valid;
   logic signed [VALUE_BITS-1:0] out_value;
   logic                         out_is_char;
   logic [1:0]                   direction;
   logic                         chooser;
   logic [CNT_BITS-1:0]          depth_now;
   logic [2:0]                   status;

   modport source(output valid, out_valid, out_value, out_is_char, direction, chooser,
                  depth_now, status, input ready);
   modport sink(input valid, out_valid, out_value, out_is_char, direction, chooser,
                depth_now, status, output ready);
endinterface

@@ rtl/color_stack_machine_execute.sv @@
// Top level of the color-driven stack machine command unit.
//
//   channel   | dir | handshake       | item
//   req_chan  | in  | valid / ready   | colors of both blocks, block size, input value
//   rsp_chan  | out | valid / ready   | output value, pointer, chooser, depth, status
//
// Items run one at a time in the back end; the front queue holds two more.
// No-op, push, pop and input end in the check state; other ops first read operands.
// Div and mod wait on the one-bit-per-cycle divider.
// Roll waits on the divider, then swaps entries over three segment reversals,
// reading both entries of a swap and then writing them back.
// Reset clears depth, pointer and chooser; stack entries need no clearing.
// A stalled result holds the back end in its last state until taken.
module color_stack_machine_execute
   import csme_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   csme_req_if.sink   req_chan,
   csme_rsp_if.source rsp_chan
);

   logic        q_valid;
   cmd_type     q_item;
   logic        q_pop;
   div_req_type div_req;
   div_rsp_type div_rsp;

   csme_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_chan),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_pop   (q_pop)
   );

   csme_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   csme_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_pop   (q_pop),
      .div_req (div_req),
      .div_rsp (div_rsp),
      .rsp     (rsp_chan)
   );

   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("queue popped while empty");

   assert property (@(posedge clock) disable iff (reset) div_req.start |=> !div_rsp.done)
      else $error("divider finished too early");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.out_valid) |->
         (rsp_chan.out_value == '0 && !rsp_chan.out_is_char))
      else $error("result without output carries output data");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.out_is_char) |-> (rsp_chan.out_value[VALUE_BITS-1:8] == '0))
      else $error("char output wider than a byte");

   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.depth_now <= CNT_BITS'(STACK_DEPTH)))
      else $error("stack depth beyond capacity");

endmodule

@@ rtl/csme_front.sv @@
// Front end: accepts command items, decodes the color change and queues the command.
module csme_front
   import csme_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   csme_req_if.sink    req,
   output logic        q_valid,
   output cmd_type     q_item,
   input  logic        q_pop
);

   cmd_type    fifo_ff [0:1];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   cmd_type    item_in;
   logic       push;

   always_comb begin
      item_in.op      = decode_op(req.from_hue, req.from_light, req.to_hue, req.to_light);
      item_in.present = req.in_present;
      case (item_in.op)
         OP_INN:  item_in.value = VALUE_BITS'({{32{req.in_value[31]}}, req.in_value});
         OP_INC:  item_in.value = VALUE_BITS'({56'd0, req.in_value[7:0]});
         default: item_in.value = VALUE_BITS'({40'd0, req.block_size});
      endcase
   end

   assign req.ready = (count_ff != 2'd2);
   assign push      = req.valid && req.ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = fifo_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (q_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, q_pop};
      end
   end

endmodule

@@ rtl/csme_div.sv @@
// Shared unsigned radix-2 divider, one quotient bit per cycle.
module csme_div
   import csme_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                  busy_ff;
   logic                  done_ff;
   logic [6:0]            iter_ff;
   logic [VALUE_BITS-1:0] dvd_ff;
   logic [VALUE_BITS-1:0] dvs_ff;
   logic [VALUE_BITS-1:0] rem_ff;
   logic [VALUE_BITS:0]   shifted;
   logic [VALUE_BITS:0]   diff;
   logic                  fits;

   assign shifted = {rem_ff, dvd_ff[VALUE_BITS-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign fits    = (shifted >= {1'b0, dvs_ff});

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = dvd_ff;
   assign div_rsp.rem  = rem_ff;

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         dvd_ff <= div_req.dividend;
         dvs_ff <= div_req.divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[VALUE_BITS-2:0], fits};
         rem_ff <= fits ? diff[VALUE_BITS-1:0] : shifted[VALUE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            iter_ff <= 7'(VALUE_BITS);
         end else if (busy_ff) begin
            iter_ff <= iter_ff - 7'd1;
            if (iter_ff == 7'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

@@ rtl/csme_back.sv @@
// Back end: runs queued commands on the value stack, pointer and chooser.
module csme_back
   import csme_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  cmd_type     q_item,
   output logic        q_pop,
   output div_req_type div_req,
   input  div_rsp_type div_rsp,
   csme_rsp_if.source  rsp
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CHK   = 4'd1;
   localparam logic [3:0] S_RDB   = 4'd2;
   localparam logic [3:0] S_RDA   = 4'd3;
   localparam logic [3:0] S_EXEC  = 4'd4;
   localparam logic [3:0] S_MUL   = 4'd5;
   localparam logic [3:0] S_DIVW  = 4'd6;
   localparam logic [3:0] S_RDIV  = 4'd7;
   localparam logic [3:0] S_RVSET = 4'd8;
   localparam logic [3:0] S_RVRL  = 4'd9;
   localparam logic [3:0] S_RVRH  = 4'd10;
   localparam logic [3:0] S_RVWL  = 4'd11;
   localparam logic [3:0] S_RVWH  = 4'd12;
   localparam logic [3:0] S_DONE  = 4'd13;

   localparam int HALF = VALUE_BITS / 2;

   logic [VALUE_BITS-1:0] mem [0:STACK_DEPTH-1];
   logic [VALUE_BITS-1:0] rd_ff;
   logic                  we;
   logic [ADDR_BITS-1:0]  waddr;
   logic [VALUE_BITS-1:0] wdata;
   logic [ADDR_BITS-1:0]  raddr;

   logic [3:0]            state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [1:0]            dir_ff, dir_in;
   logic                  chs_ff, chs_in;
   logic [VALUE_BITS-1:0] a_ff, a_in;
   logic [VALUE_BITS-1:0] b_ff, b_in;
   logic [2:0]            st_ff, st_in;
   logic                  ov_ff, ov_in;
   logic                  oc_ff, oc_in;
   logic [VALUE_BITS-1:0] oval_ff, oval_in;
   logic [1:0]            mstep_ff, mstep_in;
   logic [VALUE_BITS-1:0] prod_ff, prod_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic [CNT_BITS-1:0]   d_ff, d_in;
   logic [CNT_BITS-1:0]   rr_ff, rr_in;
   logic [ADDR_BITS-1:0]  base_ff, base_in;
   logic [ADDR_BITS-1:0]  lo_ff, lo_in;
   logic [ADDR_BITS-1:0]  hi_ff, hi_in;
   logic [1:0]            phase_ff, phase_in;
   logic [VALUE_BITS-1:0] tlo_ff, tlo_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic [CNT_BITS-1:0]   cnt_m1;
   logic [CNT_BITS-1:0]   cnt_m2;
   logic                  full;
   logic                  binary;
   logic [HALF-1:0]       mul_x, mul_y;
   logic [VALUE_BITS-1:0] abs_a, abs_b;
   logic [VALUE_BITS-1:0] quot_s, rem_s;
   logic [CNT_BITS-1:0]   rroll;
   logic [CNT_BITS-1:0]   seg_end;
   logic [1:0]            ptr_mag;

   assign cnt_m1  = cnt_ff - CNT_BITS'(1);
   assign cnt_m2  = cnt_ff - CNT_BITS'(2);
   assign full    = (cnt_ff == CNT_BITS'(STACK_DEPTH));
   assign binary  = (cmd_ff.op == OP_ADD) || (cmd_ff.op == OP_SUB) || (cmd_ff.op == OP_MUL) ||
                    (cmd_ff.op == OP_DIV) || (cmd_ff.op == OP_MOD) || (cmd_ff.op == OP_GT) ||
                    (cmd_ff.op == OP_ROLL);
   assign abs_a   = a_ff[VALUE_BITS-1] ? '0 - a_ff : a_ff;
   assign abs_b   = b_ff[VALUE_BITS-1] ? '0 - b_ff : b_ff;
   assign quot_s  = (a_ff[VALUE_BITS-1] ^ b_ff[VALUE_BITS-1]) ? '0 - div_rsp.quot : div_rsp.quot;
   assign rem_s   = a_ff[VALUE_BITS-1] ? '0 - div_rsp.rem : div_rsp.rem;
   assign ptr_mag = b_ff[VALUE_BITS-1] ? (~b_ff[1:0]) + 2'd1 : b_ff[1:0];
   assign seg_end = {1'b0, base_ff} + d_ff - CNT_BITS'(1);

   always_comb begin
      rroll = div_rsp.rem[CNT_BITS-1:0];
      if (b_ff[VALUE_BITS-1] && (rroll != '0)) begin
         rroll = d_ff - rroll;
      end
   end

   always_comb begin
      case (mstep_ff)
         2'd0:    begin mul_x = a_ff[HALF-1:0];          mul_y = b_ff[HALF-1:0];          end
         2'd1:    begin mul_x = a_ff[HALF-1:0];          mul_y = b_ff[VALUE_BITS-1:HALF]; end
         2'd2:    begin mul_x = a_ff[VALUE_BITS-1:HALF]; mul_y = b_ff[HALF-1:0];          end
         default: begin mul_x = '0;                       mul_y = '0;                       end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      cnt_in       = cnt_ff;
      dir_in       = dir_ff;
      chs_in       = chs_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      st_in        = st_ff;
      ov_in        = ov_ff;
      oc_in        = oc_ff;
      oval_in      = oval_ff;
      mstep_in     = mstep_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      d_in         = d_ff;
      rr_in        = rr_ff;
      base_in      = base_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      phase_in     = phase_ff;
      tlo_in       = tlo_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_in       = rsp_ff;
      q_pop        = 1'b0;
      we           = 1'b0;
      waddr        = cnt_m2[ADDR_BITS-1:0];
      wdata        = '0;
      raddr        = cnt_m1[ADDR_BITS-1:0];
      div_req      = '0;

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cmd_in   = q_item;
               st_in    = ST_OK;
               ov_in    = 1'b0;
               oc_in    = 1'b0;
               oval_in  = '0;
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            state_in = S_DONE;
            case (cmd_ff.op)
               OP_NONE: begin
               end
               OP_PUSH, OP_INN, OP_INC: begin
                  if ((cmd_ff.op != OP_PUSH) && !cmd_ff.present) begin
                     st_in = ST_NOIN;
                  end else if (full) begin
                     st_in = ST_OVER;
                  end else begin
                     we     = 1'b1;
                     waddr  = cnt_ff[ADDR_BITS-1:0];
                     wdata  = cmd_ff.value;
                     cnt_in = cnt_ff + CNT_BITS'(1);
                  end
               end
               OP_POP: begin
                  if (cnt_ff == '0) begin
                     st_in = ST_UNDER;
                  end else begin
                     cnt_in = cnt_m1;
                  end
               end
               default: begin
                  if ((cnt_ff == '0) || (binary && (cnt_ff == CNT_BITS'(1)))) begin
                     st_in = ST_UNDER;
                  end else begin
                     state_in = S_RDB;
                  end
               end
            endcase
         end
         S_RDB: begin
            b_in     = rd_ff;
            raddr    = cnt_m2[ADDR_BITS-1:0];
            state_in = binary ? S_RDA : S_EXEC;
         end
         S_RDA: begin
            a_in     = rd_ff;
            mstep_in = 2'd0;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_DONE;
            case (cmd_ff.op)
               OP_ADD: begin
                  we = 1'b1; wdata = a_ff + b_ff; cnt_in = cnt_m1;
               end
               OP_SUB: begin
                  we = 1'b1; wdata = a_ff - b_ff; cnt_in = cnt_m1;
               end
               OP_GT: begin
                  we     = 1'b1;
                  wdata  = VALUE_BITS'($signed(a_ff) > $signed(b_ff));
                  cnt_in = cnt_m1;
               end
               OP_MUL: begin
                  prod_in  = VALUE_BITS'(mul_x * mul_y);
                  mstep_in = 2'd1;
                  state_in = S_MUL;
               end
               OP_DIV, OP_MOD: begin
                  if (b_ff == '0) begin
                     we = 1'b1; wdata = DIVZ_VALUE; st_in = ST_DIVZ; cnt_in = cnt_m1;
                  end else if (b_ff == '1) begin
                     we     = 1'b1;
                     wdata  = (cmd_ff.op == OP_DIV) ? '0 - a_ff : '0;
                     cnt_in = cnt_m1;
                  end else begin
                     div_req.start    = 1'b1;
                     div_req.dividend = abs_a;
                     div_req.divisor  = abs_b;
                     state_in         = S_DIVW;
                  end
               end
               OP_NOT: begin
                  we    = 1'b1;
                  waddr = cnt_m1[ADDR_BITS-1:0];
                  wdata = VALUE_BITS'(b_ff == '0);
               end
               OP_PTR: begin
                  cnt_in = cnt_m1;
                  dir_in = b_ff[VALUE_BITS-1] ? dir_ff - ptr_mag : dir_ff + ptr_mag;
               end
               OP_SW: begin
                  cnt_in = cnt_m1;
                  chs_in = chs_ff ^ b_ff[0];
               end
               OP_DUP: begin
                  if (full) begin
                     st_in = ST_OVER;
                  end else begin
                     we     = 1'b1;
                     waddr  = cnt_ff[ADDR_BITS-1:0];
                     wdata  = b_ff;
                     cnt_in = cnt_ff + CNT_BITS'(1);
                  end
               end
               OP_OUTN, OP_OUTC: begin
                  cnt_in  = cnt_m1;
                  ov_in   = 1'b1;
                  oc_in   = (cmd_ff.op == OP_OUTC);
                  oval_in = (cmd_ff.op == OP_OUTC) ? (b_ff & BYTE_MASK) : b_ff;
               end
               OP_ROLL: begin
                  cnt_in = cnt_m2;
                  if (a_ff[VALUE_BITS-1]) begin
                     st_in = ST_NEGROLL;
                  end else if (a_ff > VALUE_BITS'(cnt_m2)) begin
                     st_in = ST_UNDER;
                  end else if (a_ff > VALUE_BITS'(1)) begin
                     d_in             = a_ff[CNT_BITS-1:0];
                     div_req.start    = 1'b1;
                     div_req.dividend = abs_b;
                     div_req.divisor  = a_ff;
                     state_in         = S_RDIV;
                  end
               end
               default: begin
               end
            endcase
         end
         S_MUL: begin
            prod_in  = VALUE_BITS'(mul_x * mul_y);
            mstep_in = mstep_ff + 2'd1;
            if (mstep_ff == 2'd1) begin
               acc_in = prod_ff;
            end else if (mstep_ff == 2'd2) begin
               acc_in = acc_ff + {prod_ff[HALF-1:0], {HALF{1'b0}}};
            end else begin
               we       = 1'b1;
               wdata    = acc_ff + {prod_ff[HALF-1:0], {HALF{1'b0}}};
               cnt_in   = cnt_m1;
               state_in = S_DONE;
            end
         end
         S_DIVW: begin
            if (div_rsp.done) begin
               we       = 1'b1;
               wdata    = (cmd_ff.op == OP_DIV) ? quot_s : rem_s;
               cnt_in   = cnt_m1;
               state_in = S_DONE;
            end
         end
         S_RDIV: begin
            if (div_rsp.done) begin
               if (rroll == '0) begin
                  state_in = S_DONE;
               end else begin
                  rr_in    = rroll;
                  base_in  = ADDR_BITS'(cnt_ff - d_ff);
                  phase_in = 2'd0;
                  state_in = S_RVSET;
               end
            end
         end
         S_RVSET: begin
            state_in = S_RVRL;
            case (phase_ff)
               2'd0: begin
                  lo_in = base_ff;
                  hi_in = seg_end[ADDR_BITS-1:0];
               end
               2'd1: begin
                  lo_in = base_ff;
                  hi_in = ADDR_BITS'({1'b0, base_ff} + rr_ff - CNT_BITS'(1));
               end
               default: begin
                  lo_in = ADDR_BITS'({1'b0, base_ff} + rr_ff);
                  hi_in = seg_end[ADDR_BITS-1:0];
               end
            endcase
         end
         S_RVRL: begin
            if (lo_ff >= hi_ff) begin
               if (phase_ff == 2'd2) begin
                  state_in = S_DONE;
               end else begin
                  phase_in = phase_ff + 2'd1;
                  state_in = S_RVSET;
               end
            end else begin
               raddr    = lo_ff;
               state_in = S_RVRH;
            end
         end
         S_RVRH: begin
            tlo_in   = rd_ff;
            raddr    = hi_ff;
            state_in = S_RVWL;
         end
         S_RVWL: begin
            we       = 1'b1;
            waddr    = lo_ff;
            wdata    = rd_ff;
            state_in = S_RVWH;
         end
         S_RVWH: begin
            we       = 1'b1;
            waddr    = hi_ff;
            wdata    = tlo_ff;
            lo_in    = lo_ff + ADDR_BITS'(1);
            hi_in    = hi_ff - ADDR_BITS'(1);
            state_in = S_RVRL;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in       = 1'b1;
               rsp_in.out_valid   = ov_ff;
               rsp_in.out_value   = oval_ff;
               rsp_in.out_is_char = oc_ff;
               rsp_in.direction   = dir_ff;
               rsp_in.chooser     = chs_ff;
               rsp_in.depth_now   = cnt_ff;
               rsp_in.status      = st_ff;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      st_ff    <= st_in;
      ov_ff    <= ov_in;
      oc_ff    <= oc_in;
      oval_ff  <= oval_in;
      mstep_ff <= mstep_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      d_ff     <= d_in;
      rr_ff    <= rr_in;
      base_ff  <= base_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      phase_ff <= phase_in;
      tlo_ff   <= tlo_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         dir_ff       <= 2'd0;
         chs_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         dir_ff       <= dir_in;
         chs_ff       <= chs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.out_valid   = rsp_ff.out_valid;
   assign rsp.out_value   = rsp_ff.out_value;
   assign rsp.out_is_char = rsp_ff.out_is_char;
   assign rsp.direction   = rsp_ff.direction;
   assign rsp.chooser     = rsp_ff.chooser;
   assign rsp.depth_now   = rsp_ff.depth_now;
   assign rsp.status      = rsp_ff.status;

endmodule
